FILE: design/rqi8_pkg.sv
// Shared types, constants and helper functions for the int32-to-int8 requantizer.
package rqi8_pkg;

  typedef struct packed {
    logic               signed_output;
    logic signed [31:0] zero_point;
  } rqi8_cfg_t;

  // Register indexes on the configuration port
  localparam logic REG_SIGNED_OUTPUT = 1'b0;
  localparam logic REG_ZERO_POINT    = 1'b1;

  localparam logic [7:0]  FP_EXP_SPECIAL = 8'hFF;
  localparam logic [31:0] INT32_MAX_C    = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN_C    = 32'h8000_0000;
  localparam logic signed [33:0] U8_LO = 34'sd0;
  localparam logic signed [33:0] U8_HI = 34'sd255;
  localparam logic signed [33:0] S8_LO = -34'sd128;
  localparam logic signed [33:0] S8_HI = 34'sd127;

  // Leading zero count of a 48-bit word; 48 for an all-zero word
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: design/rqi8_regs.sv
// Configuration registers behind the APB-style port.
module rqi8_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output rqi8_pkg::rqi8_cfg_t     cfg_o
);
  import rqi8_pkg::*;

  logic               signed_output_q;
  logic signed [31:0] zero_point_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_output_q <= 1'b0;
      zero_point_q    <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SIGNED_OUTPUT: signed_output_q <= pwdata[0];
        REG_ZERO_POINT:    zero_point_q    <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIGNED_OUTPUT: prdata = {31'd0, signed_output_q};
      REG_ZERO_POINT:    prdata = zero_point_q;
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.signed_output = signed_output_q;
  assign cfg_o.zero_point    = zero_point_q;

endmodule

FILE: design/requantize_int32_to_int8.sv
// Top level of the int32-to-int8 requantizer: eight-stage float pipeline and stream ports.
// Each input word carries one lane: a signed 32-bit accumulator and an IEEE single
// multiplier. The accumulator is rounded to single precision, multiplied in single
// precision (subnormals kept), rounded to an integer with ties to even, saturated to
// int32, offset by the zero point and clamped to an unsigned or signed byte. A
// non-finite multiplier gives byte 0 with tuser set. One word is accepted every
// cycle unless the output word waits; it passes the decode, normalize, round, multiply,
// normalize, round, integer and output stages. The whole pipeline holds while the
// output word waits, and tlast marks the last lane of each TILE_LANES-lane tile.
module requantize_int32_to_int8 #(
  parameter int TILE_LANES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] accumulator, [63:32] scale_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] res_byte
  output logic        m_axis_tuser,  // [0] bad_scale
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rqi8_pkg::*;

  localparam int CW = (TILE_LANES > 1) ? $clog2(TILE_LANES) : 1;
  localparam logic [CW-1:0] LANE_END = CW'(TILE_LANES - 1);

  rqi8_cfg_t cfg;

  rqi8_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic adv, in_acc;
  logic [8:1] v_q;
  logic [CW-1:0] lane_q;

  assign adv           = !v_q[8] || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Per-stage sideband: sign, bad scale, last lane
  logic [8:1] sgn_q, bad_q, last_q;

  // Stage 1: decode
  logic [31:0]        a1_q;
  logic [23:0]        ms1_q;
  logic signed [9:0]  es1_q;
  // Stage 2: normalize accumulator
  logic [31:0]        n2_q;
  logic signed [5:0]  ea2_q;
  logic [23:0]        ms2_q;
  logic signed [9:0]  es2_q;
  logic               z2_q;
  // Stage 3: round accumulator to single
  logic [23:0]        ma3_q, ms3_q;
  logic signed [5:0]  ea3_q;
  logic signed [9:0]  es3_q;
  logic               z3_q;
  // Stage 4: mantissa product
  logic [47:0]        p4_q;
  logic signed [9:0]  e4_q;
  logic               z4_q;
  // Stage 5: normalize product
  logic [47:0]        n5_q;
  logic signed [10:0] x5_q;
  logic               z5_q;
  // Stage 6: round product to single, classify
  logic [23:0]        f6_q;
  logic [4:0]         sh6_q;
  logic               small6_q, big6_q;
  // Stage 7: integer result
  logic [31:0]        r7_q;
  // Stage 8: output
  logic [7:0]         byte8_q;

  // Stage 1 logic
  logic [31:0] acc_in, sc_in, a1_d;
  logic [7:0]  se;
  logic [23:0] ms1_d;
  logic signed [9:0] es1_d;
  assign acc_in = s_axis_tdata[31:0];
  assign sc_in  = s_axis_tdata[63:32];
  assign se     = sc_in[30:23];
  assign a1_d   = acc_in[31] ? (32'd0 - acc_in) : acc_in;
  assign ms1_d  = {se != 8'd0, sc_in[22:0]};
  // subnormal scale shares the exponent of the smallest normal
  assign es1_d  = $signed({2'b00, ((se == 8'd0) ? 8'd1 : se)}) - 10'sd150;

  // Stage 2 logic
  logic [5:0] lz2;
  assign lz2 = lzc48({a1_q, 16'h0000});

  // Stage 3 logic
  logic        inc3;
  logic [24:0] sum3;
  assign inc3 = n2_q[7] && ((|n2_q[6:0]) || n2_q[8]);
  assign sum3 = {1'b0, n2_q[31:8]} + 25'(inc3);

  // Stage 5 logic
  logic [5:0] lzp5;
  assign lzp5 = lzc48(p4_q);

  // Stage 6 logic
  logic        inc6;
  logic [24:0] sum6;
  logic signed [10:0] xr6, xp6;
  assign inc6 = n5_q[23] && ((|n5_q[22:0]) || n5_q[24]);
  assign sum6 = {1'b0, n5_q[47:24]} + 25'(inc6);
  assign xr6  = x5_q + 11'(sum6[24]);
  assign xp6  = xr6 + 11'sd1;

  // Stage 7 logic
  logic [54:0] v7;
  logic        inc7;
  logic [30:0] mag7;
  logic [31:0] r7_d;
  assign v7   = 55'(f6_q) << sh6_q;
  assign inc7 = v7[23] && ((|v7[22:0]) || v7[24]);
  assign mag7 = v7[54:24] + 31'(inc7);
  always_comb begin
    if (small6_q)      r7_d = '0;
    else if (big6_q)   r7_d = sgn_q[6] ? INT32_MIN_C : INT32_MAX_C;
    else if (sgn_q[6]) r7_d = 32'd0 - {1'b0, mag7};
    else               r7_d = {1'b0, mag7};
  end

  // Stage 8 logic
  logic signed [33:0] s8, lo8, hi8, c8;
  logic [7:0] byte8_d;
  assign s8  = $signed({{2{r7_q[31]}}, r7_q}) +
               $signed({{2{cfg.zero_point[31]}}, cfg.zero_point});
  assign lo8 = cfg.signed_output ? S8_LO : U8_LO;
  assign hi8 = cfg.signed_output ? S8_HI : U8_HI;
  always_comb begin
    if (s8 < lo8)      c8 = lo8;
    else if (s8 > hi8) c8 = hi8;
    else               c8 = s8;
    byte8_d = bad_q[7] ? 8'd0 : c8[7:0];
  end

  // Control: valid bits and lane counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      lane_q <= '0;
    end else begin
      if (adv) v_q <= {v_q[7:1], in_acc};
      if (in_acc) lane_q <= (lane_q == LANE_END) ? '0 : lane_q + CW'(1);
    end
  end

  // Payload: advance all stages together
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sgn_q  <= {sgn_q[7:1], acc_in[31] ^ sc_in[31]};
      bad_q  <= {bad_q[7:1], se == FP_EXP_SPECIAL};
      last_q <= {last_q[7:1], lane_q == LANE_END};

      a1_q  <= a1_d;
      ms1_q <= ms1_d;
      es1_q <= es1_d;

      n2_q  <= a1_q << lz2[4:0];
      ea2_q <= 6'sd8 - $signed({1'b0, lz2[4:0]});
      ms2_q <= ms1_q;
      es2_q <= es1_q;
      z2_q  <= (a1_q == 32'd0) || (ms1_q == 24'd0);

      ma3_q <= sum3[24] ? 24'h80_0000 : sum3[23:0];
      ea3_q <= ea2_q + 6'(sum3[24]);
      ms3_q <= ms2_q;
      es3_q <= es2_q;
      z3_q  <= z2_q;

      p4_q <= ma3_q * ms3_q;
      e4_q <= {{4{ea3_q[5]}}, ea3_q} + es3_q;
      z4_q <= z3_q;

      n5_q <= p4_q << lzp5;
      x5_q <= 11'sd47 - $signed({5'd0, lzp5}) + {e4_q[9], e4_q};
      z5_q <= z4_q;

      f6_q     <= sum6[24] ? 24'h80_0000 : sum6[23:0];
      sh6_q    <= xp6[4:0];
      // below one half the value rounds to zero, even after the single rounding
      small6_q <= z5_q || (xr6 < -11'sd1);
      // in the top binade only the largest positive single, 2147483520, saturates
      big6_q   <= !z5_q && ((xr6 > 11'sd30) ||
                  ((xr6 == 11'sd30) && !sgn_q[5] && (sum6[23:0] == 24'hFF_FFFF)));

      r7_q    <= r7_d;
      byte8_q <= byte8_d;
    end
  end

  assign m_axis_tvalid = v_q[8];
  assign m_axis_tdata  = byte8_q;
  assign m_axis_tuser  = bad_q[8];
  assign m_axis_tlast  = last_q[8];

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("bad scale word carries nonzero byte");

  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_q <= LANE_END)
    else $error("lane counter out of range");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v_q[1])
    else $error("accepted word missing from first stage");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the int32-to-int8 requantizer stream block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rqi8_pkg::*;

  localparam int LANES = 8;

  typedef struct packed {
    logic [7:0] res_byte;
    logic       bad_scale;
    logic       tile_last;
  } lane_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // [31:0] accumulator, [63:32] scale_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] res_byte
  logic        m_axis_tuser;       // [0] bad_scale
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  requantize_int32_to_int8 #(.TILE_LANES(LANES)) dut (.*);

  always #6 clk_i = ~clk_i;

  lane_out_t  expected_bytes[$];
  int         errors = 0;
  bit         send_idle = 1'b0;
  bit         recv_idle = 1'b0;
  int         hold_cycles = 0;
  logic       mode_signed = 1'b0;
  longint     zp_shadow = 0;
  int         lanes_in_tile = 0;

  // Shift right with round to nearest, ties to even
  function automatic logic [63:0] round_shr(logic [63:0] v, int sh);
    logic [63:0] q, rem, half;
    if (sh <= 0) return v;
    if (sh >= 64) return '0;
    q    = v >> sh;
    rem  = v & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  // Round magnitude m * 2^e to single precision, gradual underflow kept
  function automatic void to_single(input logic [63:0] m, input int e,
                                    output logic [63:0] mo, output int eo);
    int n, ulp;
    n = 0;
    for (int i = 0; i < 64; i++) if (m[i]) n = i + 1;
    ulp = e + n - 24;
    if (ulp < -149) ulp = -149;
    if (m != 0 && ulp > e) begin
      mo = round_shr(m, ulp - e);
      eo = ulp;
    end else begin
      mo = m;
      eo = e;
    end
  endfunction

  function automatic lane_out_t requantize(logic [31:0] acc, logic [31:0] scale);
    lane_out_t   r;
    longint      a, v, lo, hi;
    logic [63:0] am, ma, sm, pm, mag;
    int          ea, se, pe;
    bit          neg;
    r = '0;
    r.bad_scale = (scale[30:23] == FP_EXP_SPECIAL);
    if (!r.bad_scale) begin
      a   = longint'($signed(acc));
      am  = (a < 0) ? 64'(-a) : 64'(a);
      neg = acc[31] ^ scale[31];
      to_single(am, 0, ma, ea);
      sm = (scale[30:23] == 0) ? {41'd0, scale[22:0]} : {40'd0, 1'b1, scale[22:0]};
      se = ((scale[30:23] == 0) ? 1 : int'(scale[30:23])) - 150;
      to_single(ma * sm, ea + se, pm, pe);
      if (pm == 0) begin
        v = 0;
      end else if (pe >= 39 || (pe >= 0 &&
                   (pm << pe) >= (neg ? 64'h8000_0000 : 64'h7FFF_FF80))) begin
        v = neg ? -longint'(64'h8000_0000) : longint'(INT32_MAX_C);
      end else begin
        mag = (pe >= 0) ? (pm << pe) : round_shr(pm, -pe);
        v = neg ? -longint'(mag) : longint'(mag);
      end
      v  = v + zp_shadow;
      lo = mode_signed ? -128 : 0;
      hi = mode_signed ? 127 : 255;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      r.res_byte = v[7:0];
    end
    if (lanes_in_tile + 1 >= LANES) begin
      r.tile_last   = 1'b1;
      lanes_in_tile = 0;
    end else begin
      lanes_in_tile++;
    end
    return r;
  endfunction

  task automatic report(string what, lane_out_t got, lane_out_t want);
    $display("mismatch %s: got byte %02h bad %0b last %0b, want byte %02h bad %0b last %0b",
             what, got.res_byte, got.bad_scale, got.tile_last,
             want.res_byte, want.bad_scale, want.tile_last);
    errors++;
  endtask

  // Predict on every accepted input word, check every accepted output word
  always @(posedge clk_i) begin
    lane_out_t got, want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_bytes.push_back(requantize(s_axis_tdata[31:0], s_axis_tdata[63:32]));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
      if (expected_bytes.size() == 0) begin
        report("unexpected word", got, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.res_byte !== want.res_byte) report("res_byte", got, want);
        if (got.bad_scale !== want.bad_scale) report("bad_scale", got, want);
        if (got.tile_last !== want.tile_last) report("tile_last", got, want);
      end
    end
  end

  // Output ready: long holds on request, random stall bursts while recv_idle is set, else ready
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_lane(logic [31:0] acc, logic [31:0] scale);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {scale, acc};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (reg_idx == REG_SIGNED_OUTPUT) mode_signed = value[0];
    else zp_shadow = longint'($signed(value));
  endtask

  task automatic configure(logic [31:0] mode_word, logic [31:0] zp);
    write_reg(REG_SIGNED_OUTPUT, mode_word);
    write_reg(REG_ZERO_POINT, zp);
  endtask

  function automatic logic [31:0] rand_scale();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(0, 19))
      0, 1:    ;                                        // any pattern
      2:       s[30:23] = 8'h00;                        // subnormal or zero
      3:       s[30:23] = FP_EXP_SPECIAL;               // inf or NaN
      4:       s[30:23] = 8'd127;                       // near one
      5:       s[30:23] = 8'($urandom_range(136, 254)); // huge
      default: s[30:23] = 8'($urandom_range(100, 135));
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rand_acc();
    logic [31:0] a;
    a = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -a : a;
  endfunction

  task automatic test_directed();
    logic [31:0] accs[10] = '{32'd0, 32'd1, 32'hFFFF_FFFF, INT32_MIN_C, INT32_MAX_C,
                              32'd3, 32'd5, 32'hFFFF_FFFB, 32'd16777217, 32'd300};
    logic [31:0] scales[10] = '{32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000,
                                32'h3F80_0000, 32'h3F80_0000, 32'h3F00_0000,
                                32'h3F00_0000, 32'hBF00_0000, 32'h0000_0001,
                                32'h8040_0000};
    for (int i = 0; i < 10; i++) send_lane(accs[i], scales[i]);
    send_lane(32'd7, 32'h7F80_0000);   // +inf
    send_lane(32'd7, 32'hFF80_0000);   // -inf
    send_lane(32'd7, 32'h7FC0_0001);   // NaN
    send_lane(INT32_MIN_C, 32'h7F7F_FFFF);
    send_lane(INT32_MAX_C, 32'hFF7F_FFFF);
    send_lane(32'd1000, 32'h4F00_0000);
    drain();
    configure(32'hFFFF_FFFF, INT32_MAX_C);
    send_lane(INT32_MAX_C, 32'h3F80_0000);
    send_lane(32'd0, 32'h3F80_0000);
    drain();
    configure(32'h0000_0001, INT32_MIN_C);
    send_lane(INT32_MIN_C, 32'h3F80_0000);
    send_lane(INT32_MAX_C, 32'h3F80_0000);
    send_lane(32'd129, 32'hBF80_0000);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_lane(rand_acc(), rand_scale());
    drain();
  endtask

  task automatic test_config_sweep();
    logic [31:0] zps[6] = '{32'd0, 32'hFFFF_FF80, 32'd127, 32'd128, INT32_MIN_C, INT32_MAX_C};
    for (int p = 0; p < 6; p++) begin
      configure($urandom, zps[p]);
      test_random(100);
    end
    for (int p = 0; p < 3; p++) begin
      configure(32'($urandom), 32'($urandom_range(0, 300)) - 32'd150);
      test_random(150);
    end
  endtask

  task automatic test_backpressure();
    configure(32'd1, 32'd3);
    send_idle   = 1'b0;
    hold_cycles = 60;
    for (int i = 0; i < 40; i++) send_lane(rand_acc(), rand_scale());
    drain();
    send_idle = 1'b1;
  endtask

  task automatic test_no_idle();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    configure(32'd0, $urandom_range(0, 40));
    test_random(400);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_no_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
